@@ hdl/utf8_stream_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8SD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/u8sd_pkg.sv @@
package u8sd_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Input action codes.
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_STRICT_MODE = 1'b0;

    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
    localparam logic [7:0]  ASCII_MAX      = 8'h7F;
    localparam logic [7:0]  LEAD2_MIN      = 8'hC2;
    localparam logic [7:0]  LEAD3_MIN      = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN      = 8'hF0;
    localparam logic [7:0]  E0_SECOND_MIN  = 8'hA0;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0] held;
        logic [7:0] lead;
        logic [7:0] second;
    } t_dec_state;

    typedef struct packed {
        logic        emit;
        logic [15:0] code_point;
        logic [1:0]  status;
        logic [1:0]  held_bytes;
    } t_dec_result;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

@@ hdl/u8sd_decode.sv @@
module u8sd_decode (
    input  u8sd_pkg::t_dec_state  i_state,
    input  logic                  i_strict,
    input  logic                  i_action,
    input  logic [7:0]            i_data_byte,
    output u8sd_pkg::t_dec_state  o_next,
    output u8sd_pkg::t_dec_result o_result
);

    logic        emit;
    logic        err;
    logic [15:0] ok_cp;
    logic        bad3;

    // A three-byte sequence is checked as a whole when its last byte arrives.
    assign bad3 = !u8sd_pkg::is_cont(i_state.second) || !u8sd_pkg::is_cont(i_data_byte)
                  || (i_state.lead == u8sd_pkg::LEAD3_MIN
                      && i_state.second < u8sd_pkg::E0_SECOND_MIN);

    always_comb begin
        o_next = i_state;
        emit   = 1'b0;
        err    = 1'b0;
        ok_cp  = 16'h0000;
        if (i_action == u8sd_pkg::ACT_FLUSH) begin
            if (i_state.held != u8sd_pkg::HELD_NONE) begin
                o_next.held = u8sd_pkg::HELD_NONE;
                emit        = 1'b1;
                err         = 1'b1;
            end
        end else begin
            unique case (i_state.held)
                u8sd_pkg::HELD_NONE: begin
                    if (i_data_byte <= u8sd_pkg::ASCII_MAX) begin
                        emit  = 1'b1;
                        ok_cp = {8'h00, i_data_byte};
                    end else if (i_data_byte < u8sd_pkg::LEAD2_MIN
                                 || i_data_byte >= u8sd_pkg::LEAD4_MIN) begin
                        emit = 1'b1;
                        err  = 1'b1;
                    end else begin
                        o_next.lead = i_data_byte;
                        o_next.held = u8sd_pkg::HELD_ONE;
                    end
                end
                u8sd_pkg::HELD_ONE: begin
                    if (i_state.lead < u8sd_pkg::LEAD3_MIN) begin
                        o_next.held = u8sd_pkg::HELD_NONE;
                        emit        = 1'b1;
                        err         = !u8sd_pkg::is_cont(i_data_byte);
                        ok_cp       = {5'b00000, i_state.lead[4:0], i_data_byte[5:0]};
                    end else begin
                        o_next.second = i_data_byte;
                        o_next.held   = u8sd_pkg::HELD_TWO;
                    end
                end
                default: begin
                    o_next.held = u8sd_pkg::HELD_NONE;
                    emit        = 1'b1;
                    err         = bad3;
                    ok_cp       = {i_state.lead[3:0], i_state.second[5:0], i_data_byte[5:0]};
                end
            endcase
        end

        o_result.emit       = emit;
        o_result.held_bytes = o_next.held;
        if (!err) begin
            o_result.code_point = ok_cp;
            o_result.status     = u8sd_pkg::ST_OK;
        end else if (i_strict) begin
            o_result.code_point = 16'h0000;
            o_result.status     = u8sd_pkg::ST_ERROR;
        end else begin
            o_result.code_point = u8sd_pkg::CP_REPLACEMENT;
            o_result.status     = u8sd_pkg::ST_REPLACED;
        end
    end

endmodule

@@ hdl/utf8_stream_decoder.sv @@
// UTF-8 to 16-bit code point decoder. One byte word per clock cycle is taken on the
// slave side while m_axis_tready stays high, and at most one code point word per
// byte leaves on the master side: the byte sits in an input register, one
// pass of decode logic against the held sequence bytes updates the state, and the
// result lands in an output register. Rate is set by that single decode pass, so
// the block sustains one byte per cycle while the master side keeps tready high;
// s_axis_tready follows m_axis_tready combinationally through the input stage.
// strict_mode (byte address 0, bit 0, reset 1) selects between an error status
// and U+FFFD replacement, and must only be written while the block is idle.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action
    // Code point output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] code_point, [17:16] held_bytes, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                  r_in_valid;
    logic                  r_in_action;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [15:0]           r_out_cp;
    logic [1:0]            r_out_status;
    logic [1:0]            r_out_held;
    logic                  r_strict;
    u8sd_pkg::t_dec_state  r_state;
    u8sd_pkg::t_dec_state  n_state;
    u8sd_pkg::t_dec_result dec_res;
    logic                  advance;
    logic                  cfg_write;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == u8sd_pkg::REG_STRICT_MODE);
    assign prdata    = (paddr[2] == u8sd_pkg::REG_STRICT_MODE) ? {31'd0, r_strict} : 32'd0;

    u8sd_decode u_decode (
        .i_state     (r_state),
        .i_strict    (r_strict),
        .i_action    (r_in_action),
        .i_data_byte (r_in_byte),
        .o_next      (n_state),
        .o_result    (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (cfg_write) begin
            r_strict <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser[0];
            r_in_byte   <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= dec_res.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_res.emit) begin
            r_out_cp     <= dec_res.code_point;
            r_out_status <= dec_res.status;
            r_out_held   <= dec_res.held_bytes;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_held, r_out_cp};
    assign m_axis_tuser  = r_out_status;

    // Every result closes or discards a sequence, so none leaves bytes held.
    `U8SD_ASSERT_SAME(a_result_holds_nothing, r_out_valid,
        r_out_held == u8sd_pkg::HELD_NONE, "result reports held bytes")
    `U8SD_ASSERT_SAME(a_strict_no_replace, r_out_valid && r_strict,
        r_out_status != u8sd_pkg::ST_REPLACED, "replacement in strict mode")
    `U8SD_ASSERT_SAME(a_held_in_range, 1'b1, r_state.held != 2'd3,
        "held count out of range")
    `U8SD_ASSERT_NEXT(a_flush_clears, advance && r_in_action == u8sd_pkg::ACT_FLUSH,
        r_state.held == u8sd_pkg::HELD_NONE, "flush left bytes held")

endmodule
